FILE: sv/ibss_pkg.sv
package ibss_pkg;

   // Storage geometry
   localparam int CAPACITY = 256;
   localparam int PTR_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Beat field widths
   localparam int REQ_W    = 4;
   localparam int POS_W    = 9;
   localparam int VAL_W    = 8;
   localparam int FOUND_W  = 8;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 3;

   // Request codes
   localparam logic [REQ_W-1:0] OP_PUSH_BACK  = 4'd0;
   localparam logic [REQ_W-1:0] OP_PUSH_FRONT = 4'd1;
   localparam logic [REQ_W-1:0] OP_POP_BACK   = 4'd2;
   localparam logic [REQ_W-1:0] OP_POP_FRONT  = 4'd3;
   localparam logic [REQ_W-1:0] OP_INSERT_AT  = 4'd4;
   localparam logic [REQ_W-1:0] OP_ERASE_AT   = 4'd5;
   localparam logic [REQ_W-1:0] OP_FIND       = 4'd6;
   localparam logic [REQ_W-1:0] OP_READ_FRONT = 4'd7;
   localparam logic [REQ_W-1:0] OP_READ_BACK  = 4'd8;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OOB       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   typedef logic [PTR_W-1:0] ptr_type;

   // Memory access from the sequencer; indices are logical, relative to head
   typedef struct packed {
      logic              wr_en;
      ptr_type           wr_idx;
      logic [VAL_W-1:0]  wr_data;
      ptr_type           rd_idx;
      ptr_type           head;
   } mem_req_type;

   // One result beat
   typedef struct packed {
      logic [VAL_W-1:0]    data;
      logic [FOUND_W-1:0]  found_at;
      logic [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

FILE: sv/ibss_store.sv
module ibss_store (
   input  logic                      clock,
   input  ibss_pkg::mem_req_type     mem_req,
   output logic [ibss_pkg::VAL_W-1:0] rd_data
);
   import ibss_pkg::*;

   logic [VAL_W-1:0] mem_ff [CAPACITY];
   logic [VAL_W-1:0] rd_data_ff;
   ptr_type          wr_addr;
   ptr_type          rd_addr;

   // Logical index to ring slot: head plus index, wrapped at capacity
   function automatic ptr_type ring_addr(input ptr_type head, input ptr_type idx);
      logic [PTR_W:0] sum;
      sum = {1'b0, head} + {1'b0, idx};
      if (sum >= (PTR_W+1)'(CAPACITY)) begin
         sum = sum - (PTR_W+1)'(CAPACITY);
      end
      return sum[PTR_W-1:0];
   endfunction

   assign wr_addr = ring_addr(mem_req.head, mem_req.wr_idx);
   assign rd_addr = ring_addr(mem_req.head, mem_req.rd_idx);

   // Simple dual-port array, registered read
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/ibss_ctrl.sv
module ibss_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ibss_pkg::REQ_W-1:0]    req_type,
   input  logic [ibss_pkg::POS_W-1:0]    req_position,
   input  logic [ibss_pkg::VAL_W-1:0]    req_value,
   output ibss_pkg::mem_req_type         mem_req,
   input  logic [ibss_pkg::VAL_W-1:0]    rd_data,
   output logic                          res_valid,
   output ibss_pkg::result_type          res,
   input  logic                          res_take
);
   import ibss_pkg::*;

   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_RUN  = 3'd2;
   localparam logic [2:0] S_PUT  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]       state_ff, state_in;
   ptr_type          head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [REQ_W-1:0] op_ff, op_in;
   ptr_type          pos_ff, pos_in;
   logic [VAL_W-1:0] val_ff, val_in;
   ptr_type          idx_ff, idx_in;
   result_type       res_ff, res_in;

   logic             full;
   logic             empty;
   ptr_type          back_idx;
   logic [CMP_W-1:0] pos_cmp;
   logic [CMP_W-1:0] cnt_cmp;
   mem_req_type      mreq;

   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign back_idx = PTR_W'(count_ff - CNT_W'(1));
   assign pos_cmp  = CMP_W'(req_position);
   assign cnt_cmp  = CMP_W'(count_ff);

   // Sequencer: accept, then walk the store one element a cycle
   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      count_in = count_ff;
      op_in    = op_ff;
      pos_in   = pos_ff;
      val_in   = val_ff;
      idx_in   = idx_ff;
      res_in   = res_ff;
      mreq         = '0;
      mreq.head    = head_ff;
      res_valid    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_type;
               pos_in        = PTR_W'(req_position);
               val_in        = req_value;
               res_in.data     = '0;
               res_in.found_at = '0;
               res_in.status   = ST_OK;
               state_in      = S_DONE;
               unique case (req_type)
                  OP_PUSH_BACK: begin
                     if (full) begin
                        res_in.status = ST_FULL;
                     end else begin
                        mreq.wr_en   = 1'b1;
                        mreq.wr_idx  = PTR_W'(count_ff);
                        mreq.wr_data = req_value;
                        count_in     = count_ff + CNT_W'(1);
                     end
                  end
                  OP_PUSH_FRONT: begin
                     if (full) begin
                        res_in.status = ST_FULL;
                     end else begin
                        // slot just below head
                        mreq.wr_en   = 1'b1;
                        mreq.wr_idx  = PTR_W'(CAPACITY - 1);
                        mreq.wr_data = req_value;
                        head_in      = (head_ff == '0) ? PTR_W'(CAPACITY - 1)
                                                       : head_ff - PTR_W'(1);
                        count_in     = count_ff + CNT_W'(1);
                     end
                  end
                  OP_POP_BACK: begin
                     if (empty) begin
                        res_in.status = ST_EMPTY;
                     end else begin
                        mreq.rd_idx = back_idx;
                        count_in    = count_ff - CNT_W'(1);
                        state_in    = S_READ;
                     end
                  end
                  OP_POP_FRONT: begin
                     if (empty) begin
                        res_in.status = ST_EMPTY;
                     end else begin
                        mreq.rd_idx = '0;
                        head_in     = (head_ff == PTR_W'(CAPACITY - 1)) ? '0
                                                                        : head_ff + PTR_W'(1);
                        count_in    = count_ff - CNT_W'(1);
                        state_in    = S_READ;
                     end
                  end
                  OP_INSERT_AT: begin
                     if (pos_cmp > cnt_cmp) begin
                        res_in.status = ST_OOB;
                     end else if (full) begin
                        res_in.status = ST_FULL;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                        if (pos_cmp == cnt_cmp) begin
                           mreq.wr_en   = 1'b1;
                           mreq.wr_idx  = PTR_W'(count_ff);
                           mreq.wr_data = req_value;
                        end else begin
                           // shift the tail up, back element first
                           mreq.rd_idx = back_idx;
                           idx_in      = back_idx;
                           state_in    = S_RUN;
                        end
                     end
                  end
                  OP_ERASE_AT: begin
                     if (pos_cmp >= cnt_cmp) begin
                        res_in.status = ST_OOB;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        if (pos_cmp != cnt_cmp - CMP_W'(1)) begin
                           // shift the tail down, starting just past the gap
                           mreq.rd_idx = PTR_W'(req_position) + PTR_W'(1);
                           idx_in      = PTR_W'(req_position) + PTR_W'(1);
                           state_in    = S_RUN;
                        end
                     end
                  end
                  OP_FIND: begin
                     if (empty) begin
                        res_in.status = ST_EMPTY;
                     end else begin
                        mreq.rd_idx = '0;
                        idx_in      = '0;
                        state_in    = S_RUN;
                     end
                  end
                  OP_READ_FRONT: begin
                     if (empty) begin
                        res_in.status = ST_EMPTY;
                     end else begin
                        mreq.rd_idx = '0;
                        state_in    = S_READ;
                     end
                  end
                  OP_READ_BACK: begin
                     if (empty) begin
                        res_in.status = ST_EMPTY;
                     end else begin
                        mreq.rd_idx = back_idx;
                        state_in    = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
               res_in.count = COUNT_W'(count_in);
            end
         end

         // read data is back in the cycle after the address
         S_READ: begin
            res_in.data = rd_data;
            state_in    = S_DONE;
         end

         S_RUN: begin
            unique case (op_ff)
               OP_INSERT_AT: begin
                  mreq.wr_en   = 1'b1;
                  mreq.wr_idx  = idx_ff + PTR_W'(1);
                  mreq.wr_data = rd_data;
                  if (idx_ff == pos_ff) begin
                     state_in = S_PUT;
                  end else begin
                     mreq.rd_idx = idx_ff - PTR_W'(1);
                     idx_in      = idx_ff - PTR_W'(1);
                  end
               end
               OP_ERASE_AT: begin
                  mreq.wr_en   = 1'b1;
                  mreq.wr_idx  = idx_ff - PTR_W'(1);
                  mreq.wr_data = rd_data;
                  // count already holds the reduced value: last old index
                  if (CNT_W'(idx_ff) == count_ff) begin
                     state_in = S_DONE;
                  end else begin
                     mreq.rd_idx = idx_ff + PTR_W'(1);
                     idx_in      = idx_ff + PTR_W'(1);
                  end
               end
               OP_FIND: begin
                  if (rd_data == val_ff) begin
                     res_in.data     = val_ff;
                     res_in.found_at = FOUND_W'(idx_ff);
                     res_in.status   = ST_OK;
                     state_in        = S_DONE;
                  end else if (CNT_W'(idx_ff) == count_ff - CNT_W'(1)) begin
                     res_in.status = ST_NOT_FOUND;
                     state_in      = S_DONE;
                  end else begin
                     mreq.rd_idx = idx_ff + PTR_W'(1);
                     idx_in      = idx_ff + PTR_W'(1);
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         // drop the new byte into the opened gap
         S_PUT: begin
            mreq.wr_en   = 1'b1;
            mreq.wr_idx  = pos_ff;
            mreq.wr_data = val_ff;
            state_in     = S_DONE;
         end

         S_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Working payload
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      pos_ff <= pos_in;
      val_ff <= val_in;
      idx_ff <= idx_in;
      res_ff <= res_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign mem_req   = mreq;
   assign res       = res_ff;

endmodule

FILE: sv/indexed_byte_sequence_store.sv
// Indexed byte sequence store: a bounded double-ended byte queue with
// insert/erase at an index and a search for the first matching byte.
// Request channel: req_valid/req_stall with req_type, req_position and
// req_value; a beat is taken when req_valid is high and req_stall is low.
// Response channel: rsp_valid/rsp_stall with rsp_data, rsp_found_at,
// rsp_count and rsp_status; exactly one response beat per request beat.
// The bytes live in a ring buffer in one registered-read RAM, so pushes and
// pops at either end never move data. One request is worked at a time:
// push, no-op, out-of-range and error cases go from accept straight to the
// response, as does an insert at the back; pops and reads pass through one
// RAM read, find reads elements until a match or the end, erase moves the
// elements past the position down and any other insert moves the elements
// from the position up and then writes the new byte; each moved element
// costs one RAM read and write per cycle. The worst case is an insert at
// the front of 255 bytes. The next request is taken in the cycle after the
// response moves to the output register.
// A response register decouples the sides: the next request is accepted
// while the previous response is still stalled at the output.
// Reset (synchronous) empties the sequence; RAM contents are not cleared.
module indexed_byte_sequence_store (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ibss_pkg::REQ_W-1:0]        req_type,
   input  logic [ibss_pkg::POS_W-1:0]        req_position,
   input  logic [ibss_pkg::VAL_W-1:0]        req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ibss_pkg::VAL_W-1:0]        rsp_data,
   output logic [ibss_pkg::FOUND_W-1:0]      rsp_found_at,
   output logic [ibss_pkg::COUNT_W-1:0]      rsp_count,
   output logic [ibss_pkg::STATUS_W-1:0]     rsp_status
);
   import ibss_pkg::*;

   mem_req_type      mem_req;
   logic [VAL_W-1:0] rd_data;
   logic             res_valid;
   logic             res_take;
   result_type       res;

   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff;

   ibss_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_position (req_position),
      .req_value    (req_value),
      .mem_req      (mem_req),
      .rd_data      (rd_data),
      .res_valid    (res_valid),
      .res          (res),
      .res_take     (res_take)
   );

   ibss_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // Response register: load when empty or being drained this cycle
   assign res_take     = res_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = res_take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff.data;
   assign rsp_found_at = rsp_ff.found_at;
   assign rsp_count    = rsp_ff.count;
   assign rsp_status   = rsp_ff.status;

endmodule

FILE: verif/tb_indexed_byte_sequence_store.sv
`timescale 1ns / 100ps

module tb_indexed_byte_sequence_store;
   import ibss_pkg::*;

   localparam int RANDOM_ITEMS   = 1100;
   localparam int QUIET_TAIL     = 300;   // last random items run without idling
   localparam int DRAIN_CYCLES   = 300;   // longer than the worst insert
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int MAX_PRINTS     = 100;

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_stall;
   logic [REQ_W-1:0]    req_type     = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic [VAL_W-1:0]    req_value    = '0;
   logic                rsp_valid;
   logic                rsp_stall    = 1'b0;
   logic [VAL_W-1:0]    rsp_data;
   logic [FOUND_W-1:0]  rsp_found_at;
   logic [COUNT_W-1:0]  rsp_count;
   logic [STATUS_W-1:0] rsp_status;

   // Shadow copy of the sequence, front at index zero
   logic [VAL_W-1:0] seq_bytes[$];
   result_type       expected_results[$];
   int               mismatch_count = 0;
   int               checked_beats  = 0;
   int               quiet_cycles   = 0;
   int               stall_left     = 0;
   bit               idle_on        = 1'b1;

   indexed_byte_sequence_store dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .rsp_found_at (rsp_found_at),
      .rsp_count    (rsp_count),
      .rsp_status   (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one request to the shadow sequence and return the result it gives
   function automatic result_type apply_request(input logic [REQ_W-1:0] op,
                                                input logic [POS_W-1:0] pos,
                                                input logic [VAL_W-1:0] val);
      result_type r;
      int         n;
      r = '0;
      n = seq_bytes.size();
      case (op)
         OP_PUSH_BACK: begin
            if (n >= CAPACITY) r.status = ST_FULL;
            else seq_bytes.push_back(val);
         end
         OP_PUSH_FRONT: begin
            if (n >= CAPACITY) r.status = ST_FULL;
            else seq_bytes.push_front(val);
         end
         OP_POP_BACK: begin
            if (n == 0) r.status = ST_EMPTY;
            else r.data = seq_bytes.pop_back();
         end
         OP_POP_FRONT: begin
            if (n == 0) r.status = ST_EMPTY;
            else r.data = seq_bytes.pop_front();
         end
         OP_INSERT_AT: begin
            // bounds test takes precedence over full
            if (int'(pos) > n) r.status = ST_OOB;
            else if (n >= CAPACITY) r.status = ST_FULL;
            else seq_bytes.insert(int'(pos), val);
         end
         OP_ERASE_AT: begin
            if (int'(pos) >= n) r.status = ST_OOB;
            else seq_bytes.delete(int'(pos));
         end
         OP_FIND: begin
            if (n == 0) r.status = ST_EMPTY;
            else begin
               r.status = ST_NOT_FOUND;
               for (int i = 0; i < n && r.status == ST_NOT_FOUND; i++) begin
                  if (seq_bytes[i] == val) begin
                     r.data     = val;
                     r.found_at = FOUND_W'(i);
                     r.status   = ST_OK;
                  end
               end
            end
         end
         OP_READ_FRONT: begin
            if (n == 0) r.status = ST_EMPTY;
            else r.data = seq_bytes[0];
         end
         OP_READ_BACK: begin
            if (n == 0) r.status = ST_EMPTY;
            else r.data = seq_bytes[n-1];
         end
         default: ;  // unused codes do nothing
      endcase
      r.count = COUNT_W'(seq_bytes.size());
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (mismatch_count < MAX_PRINTS)
         $display("ERROR beat %0d %s: got %0d, expected %0d",
                  checked_beats, what, got, want);
      mismatch_count++;
   endtask

   // Drive one request beat; payload changes at the falling edge
   task automatic send_request(input logic [REQ_W-1:0] op,
                               input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val);
      int gap;
      gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= op;
      req_position <= pos;
      req_value    <= val;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(apply_request(op, pos, val));
   endtask

   // Receiver back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_on && !reset && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 10);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // Compare each response beat with the oldest expected result
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("response with nothing outstanding", 16'd0, 16'd0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_data !== want.data)
               report_mismatch("data", 16'(rsp_data), 16'(want.data));
            if (rsp_found_at !== want.found_at)
               report_mismatch("found_at", 16'(rsp_found_at), 16'(want.found_at));
            if (rsp_count !== want.count)
               report_mismatch("count", 16'(rsp_count), 16'(want.count));
            if (rsp_status !== want.status)
               report_mismatch("status", 16'(rsp_status), 16'(want.status));
         end
         checked_beats++;
      end
   end

   // Watchdog: too long without any beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles", quiet_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Every request that needs elements, on an empty sequence, plus out-of-range inserts and unused codes
   task automatic test_empty_sequence();
      send_request(OP_POP_BACK, 9'd0, 8'd0);
      send_request(OP_POP_FRONT, 9'd0, 8'd0);
      send_request(OP_READ_FRONT, 9'd0, 8'd0);
      send_request(OP_READ_BACK, 9'd0, 8'd0);
      send_request(OP_FIND, 9'd0, 8'd0);
      send_request(OP_ERASE_AT, 9'd0, 8'd0);
      send_request(OP_INSERT_AT, 9'd1, 8'd7);
      send_request(OP_INSERT_AT, 9'd511, 8'd255);
      send_request(REQ_W'(9), 9'd0, 8'd0);
      send_request(REQ_W'(15), 9'd511, 8'd255);
   endtask

   // End pushes, pops and reads, indexed insert and erase, find hit and miss
   task automatic test_end_operations();
      send_request(OP_PUSH_BACK, 9'd0, 8'h00);
      send_request(OP_PUSH_FRONT, 9'd0, 8'hFF);
      send_request(OP_INSERT_AT, 9'd1, 8'hA5);
      send_request(OP_INSERT_AT, 9'd3, 8'h5A);   // insert at count
      send_request(OP_FIND, 9'd0, 8'hA5);
      send_request(OP_FIND, 9'd0, 8'h5A);
      send_request(OP_FIND, 9'd0, 8'h11);
      send_request(OP_READ_FRONT, 9'd0, 8'd0);
      send_request(OP_READ_BACK, 9'd0, 8'd0);
      send_request(OP_ERASE_AT, 9'd3, 8'd0);     // last element
      send_request(OP_ERASE_AT, 9'd0, 8'd0);
      send_request(OP_ERASE_AT, 9'd5, 8'd0);     // past the end
      send_request(OP_POP_BACK, 9'd0, 8'd0);
      send_request(OP_POP_FRONT, 9'd0, 8'd0);
      send_request(OP_POP_FRONT, 9'd0, 8'd0);    // empty again
   endtask

   // Fill to capacity, hit the full and bound cases, then drain
   task automatic test_capacity_limits();
      int n;
      int pick;
      while (seq_bytes.size() < CAPACITY - 1) begin
         n    = seq_bytes.size();
         pick = $urandom_range(0, 2);
         if (pick == 0)
            send_request(OP_PUSH_BACK, POS_W'($urandom_range(0, 511)),
                         VAL_W'($urandom_range(0, 254)));
         else if (pick == 1)
            send_request(OP_PUSH_FRONT, POS_W'($urandom_range(0, 511)),
                         VAL_W'($urandom_range(0, 254)));
         else
            send_request(OP_INSERT_AT, POS_W'($urandom_range(0, n)),
                         VAL_W'($urandom_range(0, 254)));
      end
      // a unique last byte puts the first match at the highest position
      send_request(OP_PUSH_BACK, 9'd0, 8'd255);
      send_request(OP_FIND, 9'd0, 8'd255);
      send_request(OP_PUSH_BACK, 9'd0, 8'h12);
      send_request(OP_PUSH_FRONT, 9'd0, 8'h34);
      send_request(OP_INSERT_AT, 9'd256, 8'h56);
      send_request(OP_INSERT_AT, 9'd257, 8'h78);
      send_request(OP_READ_FRONT, 9'd0, 8'd0);
      send_request(OP_READ_BACK, 9'd0, 8'd0);
      send_request(OP_ERASE_AT, 9'd256, 8'd0);
      send_request(OP_ERASE_AT, 9'd255, 8'd0);
      while (seq_bytes.size() > 0) begin
         n    = seq_bytes.size();
         pick = $urandom_range(0, 9);
         if (pick < 3)
            send_request(OP_POP_BACK, 9'd0, 8'd0);
         else if (pick < 6)
            send_request(OP_POP_FRONT, 9'd0, 8'd0);
         else if (pick < 9)
            send_request(OP_ERASE_AT, POS_W'($urandom_range(0, n - 1)), 8'd0);
         else
            send_request(OP_FIND, 9'd0, seq_bytes[$urandom_range(0, n - 1)]);
      end
   endtask

   // Random request code, weighted toward growing or shrinking
   function automatic logic [REQ_W-1:0] pick_op(input bit growing);
      int cut[9];
      int r;
      if (growing) cut = '{20, 35, 60, 68, 75, 82, 92, 95, 97};
      else         cut = '{8, 15, 23, 43, 58, 80, 90, 94, 97};
      r = $urandom_range(0, 99);
      for (int k = 0; k < 9; k++) begin
         if (r < cut[k]) begin
            case (k)
               0: return OP_PUSH_BACK;
               1: return OP_PUSH_FRONT;
               2: return OP_INSERT_AT;
               3: return OP_POP_BACK;
               4: return OP_POP_FRONT;
               5: return OP_ERASE_AT;
               6: return OP_FIND;
               7: return OP_READ_FRONT;
               default: return OP_READ_BACK;
            endcase
         end
      end
      return REQ_W'($urandom_range(9, 15));
   endfunction

   // Random traffic sweeping the count between empty and full
   task automatic test_random_traffic();
      bit               growing;
      logic [REQ_W-1:0] op;
      logic [POS_W-1:0] pos;
      logic [VAL_W-1:0] val;
      int               n;
      growing = 1'b1;
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
         n = seq_bytes.size();
         if (n == CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
         else if (n == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
         op  = pick_op(growing);
         pos = POS_W'($urandom_range(0, 511));
         if (op == OP_INSERT_AT && $urandom_range(0, 99) < 85)
            pos = POS_W'($urandom_range(0, n));
         else if (op == OP_ERASE_AT && n > 0 && $urandom_range(0, 99) < 85)
            pos = POS_W'($urandom_range(0, n - 1));
         // small values repeat often, so finds hit a variety of positions
         if (op == OP_FIND && n > 0 && $urandom_range(0, 9) < 6)
            val = seq_bytes[$urandom_range(0, n - 1)];
         else if ($urandom_range(0, 1) == 0)
            val = VAL_W'($urandom_range(0, 15));
         else
            val = VAL_W'($urandom_range(0, 255));
         send_request(op, pos, val);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_sequence();
      test_end_operations();
      test_capacity_limits();
      test_random_traffic();

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_results.size() > 0)
         report_mismatch("results never returned", 16'd0,
                         16'(expected_results.size()));
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
